>>> sv/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants for the rendezvous slot predictor: field widths, parameter
// defaults, register indexes, register reset values and arithmetic widths.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // Fixed field widths
    localparam int SLOT_IN_BITS  = 31;
    localparam int SLOT_OUT_BITS = 32;
    localparam int PERIOD_BITS   = 20;

    // Parameter defaults
    localparam int PRIME_BITS_DEF = 10;
    localparam int SLOT_BITS_DEF  = 32;

    // Configuration register indexes
    localparam int  CFG_IDX_BITS   = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_FIRST  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_SECOND = 1'b1;

    // Register reset values
    localparam int OWN_FIRST_RESET  = 37;
    localparam int OWN_SECOND_RESET = 43;

    // Width of the signed difference and correction arithmetic
    localparam int CALC_BITS = 34;

    // Bit-serial operand register length
    localparam int SER_BITS = 33;

endpackage

>>> sv/rsp_mod_unit.sv
// ----------------------------------------------------------------------------
// rsp_mod_unit
// Shared modular step: optionally doubles the running remainder, adds an
// addend and reduces both results below the modulus.
// ----------------------------------------------------------------------------
module rsp_mod_unit #(
    parameter int WIDTH = 20
) (
    input  logic [WIDTH-1:0] rem,
    input  logic [WIDTH-1:0] addend,
    input  logic [WIDTH-1:0] modulus,
    input  logic             dbl,
    output logic [WIDTH-1:0] result
);

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] reduced;
    logic [WIDTH:0] summed;
    logic [WIDTH:0] mod_ext;

    // Both operands stay below the modulus, so each reduction needs one
    // compare and subtract.
    always_comb
    begin
        mod_ext = {1'b0, modulus};
        shifted = dbl ? {rem, 1'b0} : {1'b0, rem};
        reduced = (shifted >= mod_ext) ? (shifted - mod_ext) : shifted;
        summed  = reduced + {1'b0, addend};
        if (summed >= mod_ext)
        begin
            summed = summed - mod_ext;
        end
        result = summed[WIDTH-1:0];
    end

endmodule

>>> sv/rendezvous_slot_predictor.sv
// ----------------------------------------------------------------------------
// rendezvous_slot_predictor
// Predicts the first common awake slot with a newly heard neighbour for each
// of the four own/neighbour prime combinations of a prime-pair wake schedule.
//
// Usage:
//   One input word on s_* carries the neighbour beacon and the local slot
//   count. Each input word produces four output words on m_*, one per
//   combination in the order (own first, nbr first), (own first, nbr second),
//   (own second, nbr first), (own second, nbr second); m_tlast marks the
//   fourth. s_tready is high only while the block is idle.
//   The primes are written through the cfg_* port; the user must write them
//   only while idle, since the block itself does not enforce this.
// Operation:
//   Each combination runs on one shared modular add/reduce unit and one small
//   multiplier; the inverse search steps through candidates below the searched
//   prime m. A combination with a zero prime goes straight from setup to the
//   output register.
//   Each result sits in the output register until m_tready; the block waits
//   there while the receiver stalls and resumes when the word is taken.
// Reset: rst_n clears the control state and loads primes 37 and 43.
// ----------------------------------------------------------------------------
module rendezvous_slot_predictor
    import rsp_pkg::*;
#(
    parameter int PRIME_BITS = PRIME_BITS_DEF,
    parameter int SLOT_BITS  = SLOT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PRIME_BITS-1:0]   cfg_wdata,

    // Input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // s_tdata: own_slot_number, nbr_prime_first, nbr_prime_second,
    //          nbr_slot_number, zero fill
    input  logic [((2*SLOT_IN_BITS+2*PRIME_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: is_request
    input  logic                    s_tuser,

    // Output stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // m_tdata: rendezvous_slot, rendezvous_period, zero fill
    output logic [((SLOT_OUT_BITS+PERIOD_BITS+7)/8)*8-1:0] m_tdata,
    // m_tuser: pair_valid, listen_first
    output logic [1:0]              m_tuser,
    // m_tlast: last_of_run
    output logic                    m_tlast
);

    localparam int W2     = 2 * PRIME_BITS;
    localparam int SLOT_W = (SLOT_BITS < SLOT_OUT_BITS) ? SLOT_BITS : SLOT_OUT_BITS;
    localparam int M_DW   = ((SLOT_OUT_BITS+PERIOD_BITS+7)/8)*8;
    localparam int NP1_LO = SLOT_IN_BITS;
    localparam int NP2_LO = SLOT_IN_BITS + PRIME_BITS;
    localparam int NSL_LO = SLOT_IN_BITS + 2*PRIME_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_PREP,
        ST_SETUP,
        ST_AMOD,
        ST_SEARCH,
        ST_MULP,
        ST_MODMUL,
        ST_FIX,
        ST_TMOD,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [PRIME_BITS-1:0] own_first_reg;
    logic [PRIME_BITS-1:0] own_second_reg;

    // Captured input word
    logic [SLOT_IN_BITS-1:0] own_slot_reg;
    logic [PRIME_BITS-1:0]   nbr_first_reg;
    logic [PRIME_BITS-1:0]   nbr_second_reg;
    logic                    request_reg;
    logic [SLOT_IN_BITS:0]   diff_reg;

    // Aligned offset
    logic                    listen_reg;
    logic                    c0_zero_reg;
    logic [SLOT_IN_BITS-1:0] c_reg;

    // Per-combination working registers
    logic [1:0]            combo_reg;
    logic [PRIME_BITS-1:0] a_reg;
    logic [PRIME_BITS-1:0] m_reg;
    logic [W2-1:0]         prod_b_reg;
    logic [PRIME_BITS-1:0] amod_reg;
    logic [PRIME_BITS-1:0] k_reg;
    logic [W2-1:0]         p_reg;
    logic [W2-1:0]         rem_reg;
    logic [SER_BITS-1:0]   sh_reg;
    logic [5:0]            cnt_reg;

    // Result register
    logic [SLOT_W-1:0] slot_reg;
    logic              found_reg;

    // Shared unit and multiplier
    logic [W2-1:0]         unit_addend;
    logic [W2-1:0]         unit_mod;
    logic                  unit_dbl;
    logic [W2-1:0]         unit_res;
    logic [PRIME_BITS-1:0] mul_x;
    logic [PRIME_BITS-1:0] mul_y;
    logic [W2-1:0]         mul_res;

    // Combination selection
    logic [PRIME_BITS-1:0] b0_sel;
    logic [PRIME_BITS-1:0] b1_sel;

    // Correction arithmetic
    logic [SLOT_IN_BITS-1:0] c0_val;
    logic [CALC_BITS-1:0]    t_val;
    logic [CALC_BITS-1:0]    first_val;
    logic [CALC_BITS-1:0]    fin_val;
    logic [W2-1:0]           target;
    logic                    ser_bit;

    rsp_mod_unit #(
        .WIDTH (W2)
    ) u_mod_unit (
        .rem     (rem_reg),
        .addend  (unit_addend),
        .modulus (unit_mod),
        .dbl     (unit_dbl),
        .result  (unit_res)
    );

    assign ser_bit = sh_reg[SER_BITS-1];
    assign b0_sel  = combo_reg[1] ? own_second_reg : own_first_reg;
    assign b1_sel  = combo_reg[0] ? nbr_second_reg : nbr_first_reg;
    assign target  = (m_reg == PRIME_BITS'(1)) ? '0 : W2'(1);
    assign c0_val  = c0_zero_reg ? '0 : c_reg;
    assign mul_res = W2'(mul_x) * W2'(mul_y);

    always_comb
    begin
        if (state_reg == ST_SETUP)
        begin
            mul_x = b0_sel;
            mul_y = b1_sel;
        end
        else
        begin
            mul_x = a_reg;
            mul_y = k_reg;
        end
    end

    always_comb
    begin
        unit_dbl    = 1'b1;
        unit_mod    = prod_b_reg;
        unit_addend = W2'(ser_bit);
        case (state_reg)
            ST_AMOD:
            begin
                unit_mod = W2'(m_reg);
            end
            ST_SEARCH:
            begin
                unit_mod    = W2'(m_reg);
                unit_dbl    = 1'b0;
                unit_addend = W2'(amod_reg);
            end
            ST_MODMUL:
            begin
                unit_addend = ser_bit ? p_reg : '0;
            end
            default:
            begin
                unit_addend = W2'(ser_bit);
            end
        endcase
    end

    // t = own - first, where first = r - c0; negative t means first is
    // already past the local slot.
    assign t_val     = CALC_BITS'(own_slot_reg) + CALC_BITS'(c0_val) - CALC_BITS'(rem_reg);
    assign first_val = CALC_BITS'(rem_reg) - CALC_BITS'(c0_val);
    assign fin_val   = CALC_BITS'(own_slot_reg) + CALC_BITS'(prod_b_reg)
                     - CALC_BITS'(rem_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            own_first_reg  <= PRIME_BITS'(OWN_FIRST_RESET);
            own_second_reg <= PRIME_BITS'(OWN_SECOND_RESET);
            combo_reg      <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_OWN_FIRST:  own_first_reg  <= cfg_wdata;
                    CFG_OWN_SECOND: own_second_reg <= cfg_wdata;
                    default:        own_first_reg  <= own_first_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        own_slot_reg   <= s_tdata[SLOT_IN_BITS-1:0];
                        nbr_first_reg  <= s_tdata[NP1_LO +: PRIME_BITS];
                        nbr_second_reg <= s_tdata[NP2_LO +: PRIME_BITS];
                        request_reg    <= s_tuser;
                        diff_reg       <= {1'b0, s_tdata[SLOT_IN_BITS-1:0]}
                                        - {1'b0, s_tdata[NSL_LO +: SLOT_IN_BITS]};
                        state_reg      <= ST_ALIGN;
                    end
                end

                ST_ALIGN:
                begin
                    if (request_reg && (diff_reg[SLOT_IN_BITS] || diff_reg == '0))
                    begin
                        diff_reg <= diff_reg + 1'b1;
                    end
                    else if (!request_reg && !diff_reg[SLOT_IN_BITS] && diff_reg != '0)
                    begin
                        diff_reg <= diff_reg - 1'b1;
                    end
                    state_reg <= ST_PREP;
                end

                ST_PREP:
                begin
                    listen_reg  <= !diff_reg[SLOT_IN_BITS] && (diff_reg != '0);
                    c0_zero_reg <= !diff_reg[SLOT_IN_BITS];
                    if (diff_reg[SLOT_IN_BITS])
                    begin
                        c_reg <= SLOT_IN_BITS'(-diff_reg);
                    end
                    else
                    begin
                        c_reg <= diff_reg[SLOT_IN_BITS-1:0];
                    end
                    combo_reg <= '0;
                    state_reg <= ST_SETUP;
                end

                ST_SETUP:
                begin
                    prod_b_reg <= mul_res;
                    a_reg      <= c0_zero_reg ? b0_sel : b1_sel;
                    m_reg      <= c0_zero_reg ? b1_sel : b0_sel;
                    rem_reg    <= '0;
                    sh_reg     <= {(c0_zero_reg ? b0_sel : b1_sel),
                                   {(SER_BITS-PRIME_BITS){1'b0}}};
                    cnt_reg    <= 6'(PRIME_BITS);
                    if (b0_sel == '0 || b1_sel == '0)
                    begin
                        // A zero product never yields a valid slot.
                        found_reg <= 1'b0;
                        slot_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_AMOD;
                    end
                end

                ST_AMOD:
                begin
                    sh_reg  <= {sh_reg[SER_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        amod_reg  <= unit_res[PRIME_BITS-1:0];
                        rem_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SEARCH;
                    end
                    else
                    begin
                        rem_reg <= unit_res;
                    end
                end

                ST_SEARCH:
                begin
                    // rem_reg holds (a * k) mod m for the current k.
                    if (rem_reg == target)
                    begin
                        state_reg <= ST_MULP;
                    end
                    else if (k_reg == m_reg - 1'b1)
                    begin
                        found_reg <= 1'b0;
                        slot_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        k_reg   <= k_reg + 1'b1;
                        rem_reg <= unit_res;
                    end
                end

                ST_MULP:
                begin
                    p_reg     <= mul_res;
                    rem_reg   <= '0;
                    sh_reg    <= {c_reg, {(SER_BITS-SLOT_IN_BITS){1'b0}}};
                    cnt_reg   <= 6'(SLOT_IN_BITS);
                    state_reg <= ST_MODMUL;
                end

                ST_MODMUL:
                begin
                    rem_reg <= unit_res;
                    sh_reg  <= {sh_reg[SER_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= ST_FIX;
                    end
                end

                ST_FIX:
                begin
                    found_reg <= 1'b1;
                    if (t_val[CALC_BITS-1])
                    begin
                        slot_reg  <= first_val[SLOT_W-1:0];
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        sh_reg    <= t_val[SER_BITS-1:0];
                        cnt_reg   <= 6'(SER_BITS);
                        state_reg <= ST_TMOD;
                    end
                end

                ST_TMOD:
                begin
                    rem_reg <= unit_res;
                    sh_reg  <= {sh_reg[SER_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    // Smallest slot above own_slot that is congruent to first.
                    slot_reg  <= fin_val[SLOT_W-1:0];
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        if (combo_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            combo_reg <= combo_reg + 1'b1;
                            state_reg <= ST_SETUP;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (combo_reg == 2'd3);
    assign m_tuser  = {listen_reg, found_reg};
    assign m_tdata  = M_DW'({PERIOD_BITS'(prod_b_reg), SLOT_OUT_BITS'(slot_reg)});

endmodule
